@@ hw/rtl/priority_task_order_engine_macros.svh @@
// Assertion macros shared by the scheduler modules.
`ifndef PRIORITY_TASK_ORDER_ENGINE_MACROS_SVH
`define PRIORITY_TASK_ORDER_ENGINE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define POTE_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define POTE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/pote_pkg.sv @@
package pote_pkg;

   localparam int PRIO_W  = 4;
   localparam int BURST_W = 16;
   localparam int ID_W    = 16;

   // The first task after reset gets this id.
   localparam logic [ID_W-1:0] ID_FIRST = ID_W'(1);

   // One stored task.
   typedef struct packed {
      logic [PRIO_W-1:0]  prio;
      logic [BURST_W-1:0] burst;
      logic [ID_W-1:0]    id;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;        // store the incoming item
      logic scan_init;   // start a new max-priority scan
      logic scan_read;   // read the slot at the scan index
      logic fetch_read;  // read the chosen slot for output
      logic emit;        // the result item was taken
      logic finish;      // the last result item was taken, empty the table
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_last;   // the scan index points at the last stored slot
      logic run_last;    // the pending result is the final one of the batch
   } status_type;

endpackage

@@ hw/rtl/priority_task_order_engine.sv @@
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  priority_req, burst, last_task
// rsp_      out        rsp_valid/rsp_stall  task_id, task_priority, task_burst,
//                                           overflowed, last_of_run
//
// A task item that is not marked last is taken, and the input stays open.
// After the last item, each result comes from a priority scan with one table
// read per stored slot, then a drain state finishes the compare and a fetch
// state reads the winner; an output stall holds the result item.
// The input stalls from the last item until the final result item is taken.
// Reset clears the slot valid bits, the counters and the id (back to one).

module priority_task_order_engine #(
   parameter int MAX_TASKS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [pote_pkg::PRIO_W-1:0]   req_priority_req,
   input  logic [pote_pkg::BURST_W-1:0]  req_burst,
   input  logic                          req_last_task,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [pote_pkg::ID_W-1:0]     rsp_task_id,
   output logic [pote_pkg::PRIO_W-1:0]   rsp_task_priority,
   output logic [pote_pkg::BURST_W-1:0]  rsp_task_burst,
   output logic                          rsp_overflowed,
   output logic                          rsp_last_of_run
);

   pote_pkg::cmd_type    cmd;
   pote_pkg::status_type status;

   // Sequencer for loading, scanning and emitting.
   pote_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_task (req_last_task),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .status        (status),
      .cmd           (cmd)
   );

   // Task table and priority scan.
   pote_datapath #(
      .MAX_TASKS (MAX_TASKS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_priority_req  (req_priority_req),
      .req_burst         (req_burst),
      .rsp_task_id       (rsp_task_id),
      .rsp_task_priority (rsp_task_priority),
      .rsp_task_burst    (rsp_task_burst),
      .rsp_overflowed    (rsp_overflowed),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule

@@ hw/rtl/pote_datapath.sv @@
`include "priority_task_order_engine_macros.svh"

module pote_datapath #(
   parameter int MAX_TASKS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  pote_pkg::cmd_type              cmd,
   output pote_pkg::status_type           status,
   input  logic [pote_pkg::PRIO_W-1:0]    req_priority_req,
   input  logic [pote_pkg::BURST_W-1:0]   req_burst,
   output logic [pote_pkg::ID_W-1:0]      rsp_task_id,
   output logic [pote_pkg::PRIO_W-1:0]    rsp_task_priority,
   output logic [pote_pkg::BURST_W-1:0]   rsp_task_burst,
   output logic                           rsp_overflowed,
   output logic                           rsp_last_of_run
);

   localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CNT_W = $clog2(MAX_TASKS + 1);

   // Task table and its registered read port.
   pote_pkg::entry_type mem [MAX_TASKS];
   pote_pkg::entry_type rd_ff;
   logic [IDX_W-1:0]    rd_addr;

   logic [MAX_TASKS-1:0]          valid_ff,     valid_in;
   logic [CNT_W-1:0]              count_ff,     count_in;
   logic [CNT_W-1:0]              emit_cnt_ff,  emit_cnt_in;
   logic [pote_pkg::ID_W-1:0]     next_id_ff,   next_id_in;
   logic                          drop_ff,      drop_in;
   logic [IDX_W-1:0]              scan_idx_ff,  scan_idx_in;
   logic                          scan_vld_ff,  scan_vld_in;
   logic [IDX_W-1:0]              tag_ff,       tag_in;
   logic                          found_ff,     found_in;
   logic [IDX_W-1:0]              best_ff,      best_in;
   logic [pote_pkg::PRIO_W-1:0]   best_prio_ff, best_prio_in;

   logic table_full;
   logic wr_en;

   assign table_full = (count_ff >= CNT_W'(MAX_TASKS));
   assign wr_en      = cmd.load && !table_full;
   assign rd_addr    = cmd.fetch_read ? best_ff : scan_idx_ff;

   // Status toward the controller.
   assign status.scan_last = (CNT_W'(scan_idx_ff) == CNT_W'(count_ff - CNT_W'(1)));
   assign status.run_last  = (CNT_W'(emit_cnt_ff + CNT_W'(1)) == count_ff);

   // Result fields come straight from the read register, which holds while
   // the result item waits.
   assign rsp_task_id       = rd_ff.id;
   assign rsp_task_priority = rd_ff.prio;
   assign rsp_task_burst    = rd_ff.burst;
   assign rsp_overflowed    = drop_ff;
   assign rsp_last_of_run   = status.run_last;

   // Next-state logic for loading, scanning and emitting.
   always_comb begin
      valid_in     = valid_ff;
      count_in     = count_ff;
      emit_cnt_in  = emit_cnt_ff;
      next_id_in   = next_id_ff;
      drop_in      = drop_ff;
      scan_idx_in  = scan_idx_ff;
      scan_vld_in  = cmd.scan_read;
      tag_in       = scan_idx_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      best_prio_in = best_prio_ff;

      // Append a task, or note the drop when the table is full.
      if (cmd.load) begin
         if (table_full) begin
            drop_in = 1'b1;
         end else begin
            valid_in[count_ff[IDX_W-1:0]] = 1'b1;
            count_in   = CNT_W'(count_ff + CNT_W'(1));
            next_id_in = next_id_ff + pote_pkg::ID_W'(1);
         end
      end

      // Scan index walks the stored slots one read per cycle.
      if (cmd.scan_init) begin
         scan_idx_in = '0;
         found_in    = 1'b0;
      end else if (cmd.scan_read) begin
         scan_idx_in = scan_idx_ff + IDX_W'(1);
      end

      // Compare stage: ties go to the higher slot, which was loaded later.
      if (scan_vld_ff && valid_ff[tag_ff] && (!found_ff || rd_ff.prio >= best_prio_ff)) begin
         found_in     = 1'b1;
         best_in      = tag_ff;
         best_prio_in = rd_ff.prio;
      end

      // Retire the emitted slot; empty the table after the final one.
      if (cmd.emit) begin
         valid_in[best_ff] = 1'b0;
         emit_cnt_in       = CNT_W'(emit_cnt_ff + CNT_W'(1));
      end
      if (cmd.finish) begin
         valid_in    = '0;
         count_in    = '0;
         emit_cnt_in = '0;
         drop_in     = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         count_ff    <= '0;
         emit_cnt_ff <= '0;
         next_id_ff  <= pote_pkg::ID_FIRST;
         drop_ff     <= 1'b0;
         scan_idx_ff <= '0;
         scan_vld_ff <= 1'b0;
         found_ff    <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         count_ff    <= count_in;
         emit_cnt_ff <= emit_cnt_in;
         next_id_ff  <= next_id_in;
         drop_ff     <= drop_in;
         scan_idx_ff <= scan_idx_in;
         scan_vld_ff <= scan_vld_in;
         found_ff    <= found_in;
      end
   end

   // Payload registers of the scan.
   always_ff @(posedge clock) begin
      tag_ff       <= tag_in;
      best_ff      <= best_in;
      best_prio_ff <= best_prio_in;
   end

   // Task table: one write port for loading, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[IDX_W-1:0]] <= '{prio: req_priority_req, burst: req_burst,
                                       id: next_id_ff};
      end
      if (cmd.scan_read || cmd.fetch_read) begin
         rd_ff <= mem[rd_addr];
      end
   end

   `POTE_ASSERT_SAME(a_count_bound, clock, reset, 1'b1,
      count_ff <= CNT_W'(MAX_TASKS), "stored count exceeds the table size")
   `POTE_ASSERT_SAME(a_drop_full, clock, reset, drop_ff,
      count_ff == CNT_W'(MAX_TASKS), "drop flag set while the table has room")
   `POTE_ASSERT_SAME(a_emit_valid, clock, reset, cmd.emit,
      found_ff && valid_ff[best_ff], "emitted slot is not a live task")
   `POTE_ASSERT_NEXT(a_finish_empty, clock, reset, cmd.finish,
      (valid_ff == '0) && (count_ff == '0), "table not empty after the batch")

endmodule

@@ hw/rtl/pote_ctrl.sv @@
`include "priority_task_order_engine_macros.svh"

module pote_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_last_task,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  pote_pkg::status_type  status,
   output pote_pkg::cmd_type     cmd
);

   typedef enum logic [2:0] {
      IDLE,
      SCAN,
      DRAIN,
      FETCH,
      OUTPUT
   } state_type;

   state_type state_ff, state_in;
   logic      req_stall_ff, rsp_valid_ff;

   assign req_stall = req_stall_ff;
   assign rsp_valid = rsp_valid_ff;

   // Commands decoded from the state and the handshakes.
   always_comb begin
      cmd            = '0;
      cmd.load       = (state_ff == IDLE) && req_valid;
      cmd.scan_read  = (state_ff == SCAN);
      cmd.fetch_read = (state_ff == FETCH);
      cmd.emit       = (state_ff == OUTPUT) && !rsp_stall;
      cmd.finish     = cmd.emit && status.run_last;
      cmd.scan_init  = (cmd.load && req_last_task) || (cmd.emit && !status.run_last);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         IDLE: begin
            if (cmd.load && req_last_task) begin
               state_in = SCAN;
            end
         end
         SCAN: begin
            if (status.scan_last) begin
               state_in = DRAIN;
            end
         end
         DRAIN: begin
            state_in = FETCH;
         end
         FETCH: begin
            state_in = OUTPUT;
         end
         OUTPUT: begin
            if (cmd.emit) begin
               state_in = status.run_last ? IDLE : SCAN;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   // State and registered handshake outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         req_stall_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_stall_ff <= (state_in != IDLE);
         rsp_valid_ff <= (state_in == OUTPUT);
      end
   end

   `POTE_ASSERT_SAME(a_rsp_busy, clock, reset, rsp_valid,
      req_stall, "input open while a result item is pending")
   `POTE_ASSERT_NEXT(a_last_starts, clock, reset, cmd.load && req_last_task,
      state_ff == SCAN, "last item did not start the scan")
   `POTE_ASSERT_NEXT(a_more_results, clock, reset, cmd.emit && !status.run_last,
      req_stall && !rsp_valid, "batch ended before all tasks were emitted")

endmodule
